// ===== rtl/uule_pkg.sv =====
`timescale 1ns / 1ps

package uule_pkg;

   localparam int BPL_W = 6;
   localparam logic [BPL_W-1:0] BPL_RESET = 6'd45;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_BYTES_PER_LINE = 1'b0;

   localparam logic [7:0] CHAR_BIAS = 8'h20;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_READ,
      ST_CHAR,
      ST_NEWL
   } state_type;

endpackage

// ===== rtl/uuencode_line_encoder.sv =====
`timescale 1ns / 1ps

// uuencode line encoder.
// req channel: one raw byte per item plus an end-of-data flag. Bytes are
// written into the line memory; an item that fills the line to
// bytes_per_line, or that carries end_of_data, starts output of the line.
// rsp channel: one character per item: the length character, four
// characters per three bytes, then a newline with run_last set.
// Input bytes are taken one per cycle while no line is being output
// (req_ready is low from the closing byte until the newline is registered).
// After the closing byte, ST_HEAD loads the length character into the output register when it is free.
// Each group of three bytes is read from the line memory in ST_READ (single read
// port, registered read data), then put out as four characters in ST_CHAR.
// Reset clears the fill count and control state and sets bytes_per_line to
// 45; the line memory is not cleared. When the receiver stalls, the output
// register holds its character and the sequencer waits.
// bytes_per_line is written over the csr APB port at addresses 0 to 3 (paddr[2] low).
module uuencode_line_encoder #(
   parameter int MAX_LINE_BYTES = 45
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  uule_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output uule_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [uule_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [uule_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [uule_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int CNT_W  = $clog2(MAX_LINE_BYTES + 1);
   localparam int ADDR_W = $clog2(MAX_LINE_BYTES);
   localparam int POS_W  = CNT_W + 2;
   localparam logic [uule_pkg::BPL_W-1:0] MAX_BPL = uule_pkg::BPL_W'(MAX_LINE_BYTES);

   logic [7:0] line_mem [MAX_LINE_BYTES];

   uule_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    fill_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [POS_W-1:0]    base_ff;
   logic [1:0]          rd_idx_ff;
   logic [1:0]          char_idx_ff;
   logic [23:0]         grp_ff;
   logic [7:0]          rd_data_ff;
   logic                rd_live_ff;
   logic                rsp_valid_ff;
   uule_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic [uule_pkg::BPL_W-1:0] bpl_ff;

   logic                req_fire;
   logic                out_slot;
   logic                rsp_load;
   logic                fill_room;
   logic [CNT_W-1:0]    fill_next;
   logic [uule_pkg::BPL_W-1:0] line_lim;
   logic                line_done;
   logic [POS_W-1:0]    rd_pos;
   logic                rd_hit;
   logic [7:0]          rd_byte;
   logic [5:0]          sextet;
   logic [POS_W-1:0]    base_next;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[2] == uule_pkg::REG_BYTES_PER_LINE);
   assign csr_prdata = (csr_paddr[2] == uule_pkg::REG_BYTES_PER_LINE)
                       ? {{(uule_pkg::CSR_DATA_W-uule_pkg::BPL_W){1'b0}}, bpl_ff}
                       : '0;

   assign req_ready = (state_ff == uule_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_slot  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign fill_room = (fill_ff < CNT_W'(MAX_LINE_BYTES));
   assign fill_next = fill_room ? fill_ff + CNT_W'(1) : fill_ff;

   always_comb begin
      if (bpl_ff == '0) begin
         line_lim = uule_pkg::BPL_W'(1);
      end else if (bpl_ff > MAX_BPL) begin
         line_lim = MAX_BPL;
      end else begin
         line_lim = bpl_ff;
      end
   end

   assign line_done = req_payload.end_of_data
                      || (uule_pkg::BPL_W'(fill_next) >= line_lim);

   assign rd_pos  = base_ff + POS_W'(rd_idx_ff);
   assign rd_byte = rd_live_ff ? rd_data_ff : 8'h00;
   assign base_next = base_ff + POS_W'(3);

   always_comb begin
      case (char_idx_ff)
         2'd0:    sextet = grp_ff[23:18];
         2'd1:    sextet = grp_ff[17:12];
         2'd2:    sextet = grp_ff[11:6];
         default: sextet = grp_ff[5:0];
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         uule_pkg::ST_IDLE: begin
            if (req_fire && line_done) state_in = uule_pkg::ST_HEAD;
         end
         uule_pkg::ST_HEAD: begin
            if (out_slot) state_in = uule_pkg::ST_READ;
         end
         uule_pkg::ST_READ: begin
            if (rd_idx_ff == 2'd3) state_in = uule_pkg::ST_CHAR;
         end
         uule_pkg::ST_CHAR: begin
            if (out_slot && char_idx_ff == 2'd3) begin
               state_in = (base_next < POS_W'(count_ff)) ? uule_pkg::ST_READ
                                                         : uule_pkg::ST_NEWL;
            end
         end
         uule_pkg::ST_NEWL: begin
            if (out_slot) state_in = uule_pkg::ST_IDLE;
         end
         default: state_in = uule_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rsp_load       = 1'b0;
      rsp_payload_in = '0;
      rd_hit         = 1'b0;
      case (state_ff)
         uule_pkg::ST_HEAD: begin
            rsp_load = out_slot;
            rsp_payload_in.out_char = uule_pkg::CHAR_BIAS + 8'(count_ff);
         end
         uule_pkg::ST_READ: begin
            rd_hit = (rd_idx_ff != 2'd3) && (rd_pos < POS_W'(count_ff));
         end
         uule_pkg::ST_CHAR: begin
            rsp_load = out_slot;
            rsp_payload_in.out_char = uule_pkg::CHAR_BIAS + {2'b00, sextet};
         end
         uule_pkg::ST_NEWL: begin
            rsp_load = out_slot;
            rsp_payload_in.out_char = uule_pkg::NEWLINE_CHAR;
            rsp_payload_in.run_last = 1'b1;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // line memory; reads start only after the closing byte is written
   always_ff @(posedge clock) begin
      if (req_fire && fill_room) begin
         line_mem[fill_ff[ADDR_W-1:0]] <= req_payload.data_byte;
      end
      if (rd_hit) begin
         rd_data_ff <= line_mem[rd_pos[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= uule_pkg::ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         bpl_ff       <= uule_pkg::BPL_RESET;
         rd_idx_ff    <= '0;
         char_idx_ff  <= '0;
         base_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr) bpl_ff <= csr_pwdata[uule_pkg::BPL_W-1:0];
         if (req_fire) fill_ff <= line_done ? '0 : fill_next;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            uule_pkg::ST_HEAD: begin
               base_ff     <= '0;
               rd_idx_ff   <= '0;
               char_idx_ff <= '0;
            end
            uule_pkg::ST_READ: begin
               rd_idx_ff <= rd_idx_ff + 2'd1;
            end
            uule_pkg::ST_CHAR: begin
               if (out_slot) begin
                  char_idx_ff <= char_idx_ff + 2'd1;
                  if (char_idx_ff == 2'd3) begin
                     base_ff   <= base_next;
                     rd_idx_ff <= '0;
                  end
               end
            end
            default: begin
               rd_idx_ff <= rd_idx_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && line_done) count_ff <= fill_next;
      if (state_ff == uule_pkg::ST_READ) begin
         rd_live_ff <= rd_hit;
         if (rd_idx_ff != 2'd0) grp_ff <= {grp_ff[15:0], rd_byte};
      end
      if (rsp_load) rsp_payload_ff <= rsp_payload_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_LINE_BYTES))
      else $error("fill count beyond line memory");

   a_fill_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != uule_pkg::ST_IDLE) |-> (fill_ff == '0))
      else $error("fill count not cleared while line is output");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == uule_pkg::ST_HEAD) |-> (count_ff != '0))
      else $error("empty line started");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_hit |-> (rd_pos < POS_W'(MAX_LINE_BYTES)))
      else $error("line memory read out of range");

   a_newline_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && state_ff == uule_pkg::ST_NEWL) |=> (state_ff == uule_pkg::ST_IDLE))
      else $error("newline not followed by idle");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int LINE_MAX = 45;
   localparam logic [uule_pkg::CSR_ADDR_W-1:0] BPL_ADDR = {uule_pkg::REG_BYTES_PER_LINE, 2'b00};
   localparam logic [uule_pkg::CSR_ADDR_W-1:0] UNUSED_ADDR = 3'd4;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   uule_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   uule_pkg::rsp_payload_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [uule_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [uule_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [uule_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   uule_pkg::req_payload_type byte_pending[$];
   uule_pkg::rsp_payload_type char_expect[$];

   // encoder state as seen by the scoreboard
   logic [7:0] line_bytes[LINE_MAX];
   int line_fill = 0;
   logic [uule_pkg::BPL_W-1:0] line_len_cfg = uule_pkg::BPL_RESET;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic rx_hold = 1'b0;

   int err_count = 0;
   int bytes_in = 0;
   int lines_out = 0;
   int chars_checked = 0;

   uuencode_line_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      err_count++;
   endtask

   function automatic void push_char(input logic [7:0] ch, input logic last);
      uule_pkg::rsp_payload_type r;
      r.out_char = ch;
      r.run_last = last;
      char_expect.push_back(r);
   endfunction

   function automatic int line_limit();
      if (line_len_cfg == 0)
         return 1;
      if (line_len_cfg > LINE_MAX)
         return LINE_MAX;
      return int'(line_len_cfg);
   endfunction

   // buffer one byte; when the line closes, queue its encoded characters
   function automatic void encode_byte(input uule_pkg::req_payload_type it);
      logic [7:0] a, b, c;
      if (line_fill < LINE_MAX) begin
         line_bytes[line_fill] = it.data_byte;
         line_fill++;
      end
      bytes_in++;
      if (!it.end_of_data && line_fill < line_limit())
         return;
      push_char(uule_pkg::CHAR_BIAS + 8'(line_fill), 1'b0);
      for (int p = 0; p < line_fill; p += 3) begin
         a = line_bytes[p];
         b = (p + 1 < line_fill) ? line_bytes[p + 1] : 8'h00;
         c = (p + 2 < line_fill) ? line_bytes[p + 2] : 8'h00;
         push_char(uule_pkg::CHAR_BIAS + {2'b00, a[7:2]}, 1'b0);
         push_char(uule_pkg::CHAR_BIAS + {2'b00, a[1:0], b[7:4]}, 1'b0);
         push_char(uule_pkg::CHAR_BIAS + {2'b00, b[3:0], c[7:6]}, 1'b0);
         push_char(uule_pkg::CHAR_BIAS + {2'b00, c[5:0]}, 1'b0);
      end
      push_char(uule_pkg::NEWLINE_CHAR, 1'b1);
      line_fill = 0;
      lines_out++;
   endfunction

   function automatic void add_byte(input logic [7:0] data, input logic eod);
      uule_pkg::req_payload_type it;
      it.data_byte = data;
      it.end_of_data = eod;
      byte_pending.push_back(it);
   endfunction

   // mostly whole lines (full or cut short by end of data), some stray end marks
   function automatic void plan_stream(input int count, input int lim);
      int fill, target;
      logic eod;
      fill = 0;
      target = lim;
      for (int i = 0; i < count; i++) begin
         if (fill == 0)
            target = ($urandom_range(9, 0) < 6) ? lim : $urandom_range(lim, 1);
         fill++;
         eod = (i == count - 1) || (fill == target && target < lim) ||
               ($urandom_range(19, 0) == 0);
         add_byte(8'($urandom_range(255, 0)), eod);
         if (eod || fill >= lim)
            fill = 0;
      end
   endfunction

   always @(posedge clock) begin
      logic stalled;
      stalled = req_valid && !req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            encode_byte(req_payload);
         if (!stalled) begin
            if (byte_pending.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_payload <= byte_pending.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      uule_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (char_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected item char=%h last=%b",
                                         rsp_payload.out_char, rsp_payload.run_last));
            end else begin
               want = char_expect.pop_front();
               chars_checked++;
               if (rsp_payload.out_char !== want.out_char)
                  report_mismatch($sformatf("out_char %h, expected %h",
                                            rsp_payload.out_char, want.out_char));
               if (rsp_payload.run_last !== want.run_last)
                  report_mismatch($sformatf("run_last %b, expected %b",
                                            rsp_payload.run_last, want.run_last));
            end
         end
         rsp_ready <= !rx_hold && ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   task automatic csr_write(input logic [uule_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == BPL_ADDR)
         line_len_cfg = data[uule_pkg::BPL_W-1:0];
   endtask

   task automatic csr_check(input logic [uule_pkg::CSR_ADDR_W-1:0] addr);
      logic [uule_pkg::CSR_DATA_W-1:0] got;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      got = csr_prdata;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== uule_pkg::CSR_DATA_W'(line_len_cfg))
         report_mismatch($sformatf("bytes_per_line reads %h, expected %h",
                                   got, line_len_cfg));
   endtask

   task automatic wait_drained();
      while (byte_pending.size() > 0 || req_valid || char_expect.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 21;
      recv_idle_pct = 72;
      csr_check(BPL_ADDR);
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hAA, 1'b1);
      add_byte(8'h55, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h01, 1'b0);
      add_byte(8'h7F, 1'b1);
      // leave a partial line behind, then shrink the line below its fill
      add_byte(8'hC3, 1'b0);
      add_byte(8'h3C, 1'b0);
      add_byte(8'h12, 1'b0);
      add_byte(8'h34, 1'b0);
      add_byte(8'h56, 1'b0);
      wait_drained();
      csr_write(BPL_ADDR, 32'd2);
      csr_check(BPL_ADDR);
      add_byte(8'h9E, 1'b0);
      wait_drained();
      csr_write(BPL_ADDR, 32'd0);
      csr_check(BPL_ADDR);
      add_byte(8'hE7, 1'b0);
      add_byte(8'h18, 1'b0);
      wait_drained();
      csr_write(UNUSED_ADDR, 32'd5);
      csr_check(BPL_ADDR);
      add_byte(8'h81, 1'b0);
      wait_drained();

      csr_write(BPL_ADDR, 32'd63);
      csr_check(BPL_ADDR);
      plan_stream(95, LINE_MAX);
      wait_drained();

      send_idle_pct = 72;
      recv_idle_pct = 21;
      csr_write(BPL_ADDR, 32'd3);
      csr_check(BPL_ADDR);
      plan_stream(60, 3);
      wait_drained();
      csr_write(BPL_ADDR, 32'd45);
      csr_check(BPL_ADDR);
      plan_stream(50, LINE_MAX);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(BPL_ADDR, 32'd17);
      csr_check(BPL_ADDR);
      plan_stream(60, 17);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (500) @(posedge clock);
      rx_hold <= 1'b0;
      wait_drained();
      csr_write(BPL_ADDR, 32'd1);
      csr_check(BPL_ADDR);
      plan_stream(20, 1);
      wait_drained();

      $display("Encoded %0d bytes into %0d lines, %0d characters checked.",
               bytes_in, lines_out, chars_checked);
      $display("Line lengths 0, 1, 2, 3, 17, 45 and 63, shrink below fill, long output stall.");
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Timeout with %0d characters outstanding.", char_expect.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/uule_pkg.sv
rtl/uuencode_line_encoder.sv
sim/tb.sv
